// File: src/ntc_pkg.sv
// Shared constants, status codes and pipeline sideband type for the NTC
// temperature unit. No dependencies.
package ntc_pkg;

  localparam int unsigned AdcBitsDef = 12;
  localparam int unsigned FracBits   = 24;
  localparam int unsigned MantW      = 31;  // Q30 mantissa, 1 <= m < 2

  localparam logic [63:0] Rs0      = 64'd12100;
  localparam logic [63:0] Rs1      = 64'd36500;
  localparam logic [63:0] Rp1      = 64'd330000;
  localparam logic [63:0] Rs2      = 64'd475000;
  localparam logic [63:0] Rp2      = 64'd2000000;
  localparam logic [63:0] Ln2Q30   = 64'd744261118;
  localparam logic [63:0] KQ24     = 64'd50576887;
  localparam logic [63:0] BetaQ24  = 64'd5788139520000;
  localparam logic [16:0] ZeroCenti = 17'd27315;
  // quotient limits beyond which the Celsius result leaves 16 bits
  localparam logic [63:0] SatHiQ   = 64'd60082;
  localparam logic [63:0] SatLoQ   = 64'd5453;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_SAT     = 2'd1,
    STAT_INVALID = 2'd2
  } ntc_status_e;

  typedef struct packed {
    logic valid;
    logic inval;
    logic xzero;
    logic neg;
  } ntc_side_t;

endpackage

// File: src/ntc_front.sv
// Front end: divider ratio num/den, leading-one search and normalization.
// Depends on ntc_pkg.
module ntc_front #(
  parameter int unsigned AdcBits = ntc_pkg::AdcBitsDef,
  parameter int unsigned NumW    = AdcBits + 41,
  parameter int unsigned EW      = $clog2(NumW)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [7:0]                adc_low_byte_i,
  input  logic [7:0]                adc_high_byte_i,
  input  logic [1:0]                bias_range_i,
  output logic [ntc_pkg::MantW-1:0] mn_o,
  output logic [ntc_pkg::MantW-1:0] md_o,
  output logic [EW-1:0]             en_o,
  output logic [EW-1:0]             ed_o,
  output ntc_pkg::ntc_side_t        side_o
);
  import ntc_pkg::*;

  localparam logic [AdcBits-1:0] Mx = '1;

  logic [15:0]      word;
  logic [NumW-1:0]  v, top, sub, num_d, den_d;
  logic             bad;
  logic [NumW-1:0]  num_q, den_q, num2_q, den2_q;
  ntc_side_t        s1_q, s2_q, s3_q;
  logic [EW-1:0]    en_d, ed_d, en_q, ed_q, en3_q, ed3_q;
  logic [NumW-1:0]  nn, dn;
  logic [MantW-1:0] mn_q, md_q;

  assign word = {adc_high_byte_i, adc_low_byte_i};
  assign v    = NumW'(word[AdcBits-1:0]);

  always_comb begin
    top   = '0;
    sub   = '0;
    num_d = '0;
    den_d = '0;
    bad   = 1'b1;
    unique case (bias_range_i)
      2'd0: begin
        num_d = v * NumW'(Rs0);
        den_d = NumW'(Mx) - v;
        bad   = (v == NumW'(Mx));
      end
      2'd1: begin
        top   = NumW'(Rp1) * NumW'(Mx);
        sub   = v * NumW'(Rs1 + Rp1);
        num_d = v * NumW'(Rs1 * Rp1);
        den_d = top - sub;
        bad   = (sub >= top);
      end
      2'd2: begin
        top   = NumW'(Rp2) * NumW'(Mx);
        sub   = v * NumW'(Rs2 + Rp2);
        num_d = v * NumW'(Rs2 * Rp2);
        den_d = top - sub;
        bad   = (sub >= top);
      end
      default: bad = 1'b1;
    endcase
    if (v == '0) bad = 1'b1;
  end

  // index of top set bit
  always_comb begin
    en_d = '0;
    ed_d = '0;
    for (int i = 0; i < NumW; i++) begin
      if (num_q[i]) en_d = EW'(i);
      if (den_q[i]) ed_d = EW'(i);
    end
  end

  assign nn = num2_q << (EW'(NumW - 1) - en_q);
  assign dn = den2_q << (EW'(NumW - 1) - ed_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
      s3_q <= '0;
    end else begin
      s1_q <= '{valid: start_i, inval: bad, xzero: 1'b0, neg: 1'b0};
      s2_q <= s1_q;
      s3_q <= s2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    den_q  <= den_d;
    num2_q <= num_q;
    den2_q <= den_q;
    en_q   <= en_d;
    ed_q   <= ed_d;
    mn_q   <= nn[NumW-1 -: MantW];
    md_q   <= dn[NumW-1 -: MantW];
    en3_q  <= en_q;
    ed3_q  <= ed_q;
  end

  assign mn_o   = mn_q;
  assign md_o   = md_q;
  assign en_o   = en3_q;
  assign ed_o   = ed3_q;
  assign side_o = s3_q;
endmodule

// File: src/ntc_log2.sv
// Pipelined log2 fraction: one squaring step per stage for both operands.
// Depends on ntc_pkg.
module ntc_log2 #(
  parameter int unsigned EW = 6
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [ntc_pkg::MantW-1:0]    mn_i,
  input  logic [ntc_pkg::MantW-1:0]    md_i,
  input  logic [EW-1:0]                en_i,
  input  logic [EW-1:0]                ed_i,
  input  ntc_pkg::ntc_side_t           side_i,
  output logic [EW+ntc_pkg::FracBits-1:0] ln_o,
  output logic [EW+ntc_pkg::FracBits-1:0] ld_o,
  output ntc_pkg::ntc_side_t           side_o
);
  import ntc_pkg::*;

  logic [MantW-1:0]    mn_q [FracBits];
  logic [MantW-1:0]    md_q [FracBits];
  logic [FracBits-1:0] fn_q [FracBits];
  logic [FracBits-1:0] fd_q [FracBits];
  logic [EW-1:0]       en_q [FracBits];
  logic [EW-1:0]       ed_q [FracBits];
  ntc_side_t           s_q  [FracBits];

  for (genvar g = 0; g < FracBits; g++) begin : g_stage
    logic [MantW-1:0]    mn_s, md_s;
    logic [FracBits-1:0] fn_s, fd_s;
    logic [EW-1:0]       en_s, ed_s;
    ntc_side_t           s_s;
    logic [2*MantW-1:0]  pn, pd;
    logic [MantW:0]      qn, qd;

    if (g == 0) begin : g_first
      assign mn_s = mn_i;
      assign md_s = md_i;
      assign fn_s = '0;
      assign fd_s = '0;
      assign en_s = en_i;
      assign ed_s = ed_i;
      assign s_s  = side_i;
    end else begin : g_next
      assign mn_s = mn_q[g-1];
      assign md_s = md_q[g-1];
      assign fn_s = fn_q[g-1];
      assign fd_s = fd_q[g-1];
      assign en_s = en_q[g-1];
      assign ed_s = ed_q[g-1];
      assign s_s  = s_q[g-1];
    end

    assign pn = mn_s * mn_s;
    assign pd = md_s * md_s;
    assign qn = pn[2*MantW-1 -: MantW+1];  // (m*m) >> 30
    assign qd = pd[2*MantW-1 -: MantW+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        s_q[g] <= '0;
      end else begin
        s_q[g] <= s_s;
      end
    end

    always_ff @(posedge clk_i) begin
      mn_q[g] <= qn[MantW] ? qn[MantW:1] : qn[MantW-1:0];
      md_q[g] <= qd[MantW] ? qd[MantW:1] : qd[MantW-1:0];
      fn_q[g] <= {fn_s[FracBits-2:0], qn[MantW]};
      fd_q[g] <= {fd_s[FracBits-2:0], qd[MantW]};
      en_q[g] <= en_s;
      ed_q[g] <= ed_s;
    end
  end

  assign ln_o   = {en_q[FracBits-1], fn_q[FracBits-1]};
  assign ld_o   = {ed_q[FracBits-1], fd_q[FracBits-1]};
  assign side_o = s_q[FracBits-1];
endmodule

// File: src/ntc_scale.sv
// Log difference, ln2 scaling, beta offset and divider operand prep.
// Depends on ntc_pkg.
module ntc_scale #(
  parameter int unsigned EW = 6,
  parameter int unsigned XW = EW + 26,
  parameter int unsigned NW = ((XW > 44) ? XW : 44) + 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [EW+ntc_pkg::FracBits-1:0] ln_i,
  input  logic [EW+ntc_pkg::FracBits-1:0] ld_i,
  input  ntc_pkg::ntc_side_t              side_i,
  output logic [NW-1:0]                   n_o,
  output logic [XW-1:0]                   d_o,
  output ntc_pkg::ntc_side_t              side_o
);
  import ntc_pkg::*;

  localparam int unsigned LW = EW + FracBits;

  logic signed [LW:0] l;
  logic [LW-1:0]      mag_q, mag2_q;
  logic [LW+30:0]     prod;
  logic               lneg_q, lneg2_q;
  logic signed [XW-1:0] lnr, x;
  logic [XW-1:0]      ax;
  logic [NW-1:0]      n_q;
  logic [XW-1:0]      d_q;
  ntc_side_t          sa_q, sb_q, sc_q;

  assign l    = signed'({1'b0, ln_i}) - signed'({1'b0, ld_i});
  assign prod = (LW+31)'(mag_q) * (LW+31)'(Ln2Q30) + (LW+31)'(64'd1 << 29);
  assign lnr  = lneg2_q ? -signed'(XW'(mag2_q)) : signed'(XW'(mag2_q));
  assign x    = signed'(XW'(KQ24)) + lnr;
  assign ax   = x[XW-1] ? XW'(-x) : XW'(x);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_q <= '0;
      sb_q <= '0;
      sc_q <= '0;
    end else begin
      sa_q <= side_i;
      sb_q <= sa_q;
      sc_q <= '{valid: sb_q.valid, inval: sb_q.inval,
                xzero: (x == '0), neg: x[XW-1]};
    end
  end

  always_ff @(posedge clk_i) begin
    lneg_q  <= l[LW];
    mag_q   <= l[LW] ? LW'(-l) : LW'(l);
    lneg2_q <= lneg_q;
    mag2_q  <= prod[LW+29:30];
    // round half away from zero: add half the divisor
    n_q     <= NW'(BetaQ24) + NW'(ax >> 1);
    d_q     <= ax;
  end

  assign n_o    = n_q;
  assign d_o    = d_q;
  assign side_o = sc_q;
endmodule

// File: src/ntc_div.sv
// Restoring divider, one quotient bit per pipeline stage.
// Depends on ntc_pkg.
module ntc_div #(
  parameter int unsigned NW = 45,
  parameter int unsigned DW = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [NW-1:0]      n_i,
  input  logic [DW-1:0]      d_i,
  input  ntc_pkg::ntc_side_t side_i,
  output logic [NW-1:0]      q_o,
  output ntc_pkg::ntc_side_t side_o
);
  import ntc_pkg::*;

  logic [NW-1:0] n_q [NW];
  logic [NW-1:0] q_q [NW];
  logic [DW-1:0] r_q [NW];
  logic [DW-1:0] d_q [NW];
  ntc_side_t     s_q [NW];

  for (genvar g = 0; g < NW; g++) begin : g_stage
    logic [NW-1:0] n_s, q_s;
    logic [DW-1:0] r_s, d_s;
    ntc_side_t     s_s;
    logic [DW:0]   rr;
    logic          ge;

    if (g == 0) begin : g_first
      assign n_s = n_i;
      assign q_s = '0;
      assign r_s = '0;
      assign d_s = d_i;
      assign s_s = side_i;
    end else begin : g_next
      assign n_s = n_q[g-1];
      assign q_s = q_q[g-1];
      assign r_s = r_q[g-1];
      assign d_s = d_q[g-1];
      assign s_s = s_q[g-1];
    end

    assign rr = {r_s, n_s[NW-1]};
    assign ge = (rr >= {1'b0, d_s});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        s_q[g] <= '0;
      end else begin
        s_q[g] <= s_s;
      end
    end

    always_ff @(posedge clk_i) begin
      n_q[g] <= {n_s[NW-2:0], 1'b0};
      q_q[g] <= {q_s[NW-2:0], ge};
      r_q[g] <= ge ? DW'(rr - {1'b0, d_s}) : DW'(rr);
      d_q[g] <= d_s;
    end
  end

  assign q_o    = q_q[NW-1];
  assign side_o = s_q[NW-1];
endmodule

// File: src/ntc_thermistor_temperature_unit.sv
// NTC thermistor to Celsius converter, beta equation in fixed point.
// Stages: front end, log2, scale, divider (NW = 45 quotient bits at ADC_BITS 12) and output register.
// Throughput one beat per cycle; busy is always low, results cannot be stalled.
// Reset clears the stage sideband and valid registers only; data registers are not reset.
// Depends on ntc_pkg and ntc_front, ntc_log2, ntc_scale, ntc_div.
module ntc_thermistor_temperature_unit #(
  parameter int unsigned ADC_BITS = ntc_pkg::AdcBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  adc_low_byte_i,
  input  logic [7:0]  adc_high_byte_i,
  input  logic [1:0]  bias_range_i,
  output logic        result_valid_o,
  output logic signed [15:0] temperature_centi_o,
  output logic [1:0]  status_o
);
  import ntc_pkg::*;

  localparam int unsigned NumW = ADC_BITS + 41;
  localparam int unsigned EW   = $clog2(NumW);
  localparam int unsigned XW   = EW + 26;
  localparam int unsigned NW   = ((XW > 44) ? XW : 44) + 1;

  logic [MantW-1:0]       mn, md;
  logic [EW-1:0]          en, ed;
  logic [EW+FracBits-1:0] ln, ld;
  logic [NW-1:0]          n, q;
  logic [XW-1:0]          d;
  ntc_side_t              s_f, s_l, s_s, s_d;
  logic [15:0]            temp_d, temp_q;
  ntc_status_e            stat_d, stat_q;
  logic                   vld_q;

  assign busy = 1'b0;

  ntc_front #(.AdcBits(ADC_BITS), .NumW(NumW), .EW(EW)) u_front (
    .clk_i, .rst_ni, .start_i(start),
    .adc_low_byte_i, .adc_high_byte_i, .bias_range_i,
    .mn_o(mn), .md_o(md), .en_o(en), .ed_o(ed), .side_o(s_f)
  );

  ntc_log2 #(.EW(EW)) u_log2 (
    .clk_i, .rst_ni, .mn_i(mn), .md_i(md), .en_i(en), .ed_i(ed),
    .side_i(s_f), .ln_o(ln), .ld_o(ld), .side_o(s_l)
  );

  ntc_scale #(.EW(EW), .XW(XW), .NW(NW)) u_scale (
    .clk_i, .rst_ni, .ln_i(ln), .ld_i(ld), .side_i(s_l),
    .n_o(n), .d_o(d), .side_o(s_s)
  );

  ntc_div #(.NW(NW), .DW(XW)) u_div (
    .clk_i, .rst_ni, .n_i(n), .d_i(d), .side_i(s_s),
    .q_o(q), .side_o(s_d)
  );

  // kelvin to Celsius with saturation
  always_comb begin
    logic [16:0] q17;
    q17    = 17'(q[15:0]);
    temp_d = '0;
    stat_d = STAT_OK;
    if (s_d.inval) begin
      stat_d = STAT_INVALID;
    end else if (s_d.xzero) begin
      temp_d = 16'h7fff;
      stat_d = STAT_SAT;
    end else if (!s_d.neg) begin
      if (64'(q) > SatHiQ) begin
        temp_d = 16'h7fff;
        stat_d = STAT_SAT;
      end else begin
        temp_d = 16'(q17 - ZeroCenti);
      end
    end else begin
      if (64'(q) > SatLoQ) begin
        temp_d = 16'h8000;
        stat_d = STAT_SAT;
      end else begin
        temp_d = 16'(17'd0 - (q17 + ZeroCenti));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= s_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    temp_q <= temp_d;
    stat_q <= stat_d;
  end

  assign result_valid_o      = vld_q;
  assign temperature_centi_o = signed'(temp_q);
  assign status_o            = stat_q;
endmodule

// File: dv/ntc_thermistor_temperature_unit_tb.sv
// Testbench for ntc_thermistor_temperature_unit: drives ADC byte pairs and range
// selectors, predicts temperature and status in fixed point, checks every beat.
// Depends on ntc_pkg and the RTL of the unit.
module ntc_thermistor_temperature_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ntc_pkg::*;

  localparam int unsigned LatencyCyc = 76;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [7:0]        adc_low_byte_i;
  logic [7:0]        adc_high_byte_i;
  logic [1:0]        bias_range_i;
  logic              result_valid_o;
  logic signed [15:0] temperature_centi_o;
  logic [1:0]        status_o;

  typedef struct packed {
    logic signed [15:0] temp;
    ntc_status_e        stat;
  } temp_reading_t;

  temp_reading_t pending_temps[$];
  int unsigned   n_mismatch;
  int unsigned   n_sent;
  int unsigned   n_checked;
  int unsigned   n_sat;
  int unsigned   n_inval;

  ntc_thermistor_temperature_unit uut (
    .clk_i, .rst_ni, .start, .busy,
    .adc_low_byte_i, .adc_high_byte_i, .bias_range_i,
    .result_valid_o, .temperature_centi_o, .status_o
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // log2 in Q24 by repeated squaring of a Q30 mantissa
  function automatic longint log2_fixed(longint unsigned n);
    int               e;
    longint unsigned  m;
    longint           frac;
    e = 63;
    frac = 0;
    while (e > 0 && n[e] == 1'b0) e--;
    if (e >= 30) m = n >> (e - 30);
    else m = n << (30 - e);
    for (int i = 0; i < 24; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= 64'h8000_0000) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    return (longint'(e) << 24) | frac;
  endfunction

  function automatic temp_reading_t convert_reading(logic [7:0] lo, logic [7:0] hi,
                                                    logic [1:0] rng);
    temp_reading_t   r;
    longint unsigned code, mx, num, den, rs, rp, top, sub, mag, q, ux;
    longint          l2, x, tc;
    mx = (64'd1 << 12) - 1;
    code = {hi, lo} & mx;
    r.temp = '0;
    r.stat = STAT_INVALID;
    if (rng == 2'd3 || code == 0) return r;
    if (rng == 2'd0) begin
      if (code >= mx) return r;
      num = code * Rs0;
      den = mx - code;
    end else begin
      rs = (rng == 2'd1) ? Rs1 : Rs2;
      rp = (rng == 2'd1) ? Rp1 : Rp2;
      top = rp * mx;
      sub = code * (rs + rp);
      if (sub >= top) return r;
      num = code * rs * rp;
      den = top - sub;
    end
    l2 = log2_fixed(num) - log2_fixed(den);
    mag = (l2 < 0) ? longint'(-l2) : longint'(l2);
    mag = (mag * Ln2Q30 + (64'd1 << 29)) >> 30;
    x = longint'(KQ24) + ((l2 < 0) ? -longint'(mag) : longint'(mag));
    r.stat = STAT_SAT;
    if (x == 0) begin
      r.temp = 16'sd32767;
      return r;
    end
    ux = (x < 0) ? longint'(-x) : longint'(x);
    q = (BetaQ24 + ux / 2) / ux;
    tc = ((x < 0) ? -longint'(q) : longint'(q)) - 27315;
    if (tc > 32767) r.temp = 16'sd32767;
    else if (tc < -32768) r.temp = 16'sh8000;
    else begin
      r.temp = tc[15:0];
      r.stat = STAT_OK;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    n_mismatch++;
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  // one conversion beat; gap drawn per beat
  task automatic send_reading(logic [7:0] lo, logic [7:0] hi, logic [1:0] rng,
                              bit with_gap = 1);
    int unsigned gap;
    gap = with_gap ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    adc_low_byte_i <= lo;
    adc_high_byte_i <= hi;
    bias_range_i <= rng;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_temps.push_back(convert_reading(lo, hi, rng));
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic go_quiet();
    start <= 1'b0;
    while (pending_temps.size() != 0) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    temp_reading_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_temps.size() == 0) begin
        report_mismatch("unexpected beat, status", status_o, -1);
      end else begin
        want = pending_temps.pop_front();
        n_checked++;
        if (want.stat == STAT_SAT) n_sat++;
        if (want.stat == STAT_INVALID) n_inval++;
        if (temperature_centi_o !== want.temp)
          report_mismatch("temperature_centi", temperature_centi_o, want.temp);
        if (status_o !== want.stat) report_mismatch("status", status_o, want.stat);
      end
    end
  end

  task automatic test_directed();
    // zero code, full-scale code, range three, upper nibble masking
    send_reading(8'h00, 8'h00, 2'd0);
    send_reading(8'h00, 8'hF0, 2'd1);
    send_reading(8'hFF, 8'h0F, 2'd0);
    send_reading(8'hFF, 8'hFF, 2'd1);
    send_reading(8'hFF, 8'h0F, 2'd2);
    send_reading(8'h00, 8'h08, 2'd3);
    send_reading(8'hFF, 8'hFF, 2'd3);
    // one lsb codes: hot side, saturates high in ranges zero and one
    for (int r = 0; r < 3; r++) send_reading(8'h01, 8'h00, r[1:0]);
    // near top of divider: cold side, in range for range zero, invalid for ranges one and two
    send_reading(8'hFE, 8'h0F, 2'd0);
    send_reading(8'hA0, 8'h0F, 2'd1);
    send_reading(8'hD0, 8'h0E, 2'd2);
    // mid scale, in range
    for (int r = 0; r < 3; r++) send_reading(8'h00, 8'h08, r[1:0], 0);
    send_reading(8'h55, 8'hA5, 2'd1, 0);
    send_reading(8'hAA, 8'h5A, 2'd2, 0);
    go_quiet();
  endtask

  task automatic test_random(int unsigned count);
    logic [11:0] code;
    logic [1:0]  rng;
    for (int unsigned i = 0; i < count; i++) begin
      // mostly valid ranges; back-to-back bursts every few hundred beats
      rng = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      code = 12'($urandom);
      send_reading(code[7:0], {4'($urandom), code[11:8]}, rng,
                   (i % 300) > 60);
      if (i == count / 2) go_quiet();
    end
    go_quiet();
  endtask

  initial begin
    n_mismatch = 0; n_sent = 0; n_checked = 0; n_sat = 0; n_inval = 0;
    start = 1'b0;
    adc_low_byte_i = '0;
    adc_high_byte_i = '0;
    bias_range_i = '0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(2000);
    repeat (LatencyCyc + 10) @(posedge clk_i);
    $display("Covered %0d conversions, %0d checked (%0d saturated, %0d invalid).",
             n_sent, n_checked, n_sat, n_inval);
    if (n_mismatch == 0 && pending_temps.size() == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #2ms;
    $display("Timeout with %0d beats outstanding.", pending_temps.size());
    $display("end of test: mismatches");
    $finish;
  end
endmodule
